// ===== sv/tgcw_pkg.sv =====
// shared types and constants for the text grid cursor writer
// no dependencies; imported by every module of the block but tgcw_ram
`default_nettype none

package tgcw_pkg;

    localparam int TGCW_COLUMNS = 80;
    localparam int TGCW_ROWS    = 25;
    localparam int CHAR_W       = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam int         TAB_MASK = 7;

    typedef logic [2:0] t_kind;
    localparam t_kind K_CHAR = 3'd0;
    localparam t_kind K_CR   = 3'd1;
    localparam t_kind K_LF   = 3'd2;
    localparam t_kind K_TAB  = 3'd3;
    localparam t_kind K_READ = 3'd4;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_in;
        logic [4:0] read_row;
        logic [6:0] read_column;
        logic       in_range;
        logic       chunk_end;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/tgcw_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// depends on nothing
`default_nettype none

module tgcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tgcw_front.sv =====
// front end: takes input beats, classifies them and queues commands
// depends on tgcw_pkg
`default_nettype none

module tgcw_front
    import tgcw_pkg::*;
#(
    parameter int COLUMNS = TGCW_COLUMNS,
    parameter int ROWS    = TGCW_ROWS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_run,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_operation,
    input  wire  [7:0]  i_byte_in,
    input  wire  [4:0]  i_read_row,
    input  wire  [6:0]  i_read_column,
    input  wire         i_chunk_end,
    output logic        o_q_valid,
    output t_cmd        o_q_cmd,
    input  wire         i_q_pop
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_cmd             w_cmd;
    logic             w_push;
    t_cmd             r_q [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QAW:0]     r_cnt, n_cnt;
    logic             w_full;

    always_comb begin
        w_cmd.byte_in     = i_byte_in;
        w_cmd.read_row    = i_read_row;
        w_cmd.read_column = i_read_column;
        w_cmd.chunk_end   = i_chunk_end;
        w_cmd.in_range    = ({4'b0, i_read_row} < 9'(ROWS))
                         && ({2'b0, i_read_column} < 9'(COLUMNS));
        priority if (i_operation) begin
            w_cmd.kind = K_READ;
        end else if (i_byte_in == CH_CR) begin
            w_cmd.kind = K_CR;
        end else if (i_byte_in == CH_LF) begin
            w_cmd.kind = K_LF;
        end else if (i_byte_in == CH_TAB) begin
            w_cmd.kind = K_TAB;
        end else begin
            w_cmd.kind = K_CHAR;
        end
    end

    assign w_full    = (r_cnt == (QAW+1)'(QUEUE_DEPTH));
    assign o_ready   = i_run && !w_full;
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_cmd   = r_q[r_rp];

    always_comb begin
        n_wp  = w_push ? r_wp + QAW'(1) : r_wp;
        n_rp  = i_q_pop ? r_rp + QAW'(1) : r_rp;
        n_cnt = r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tgcw_back.sv =====
// back end: clears the grid, runs queued commands against cursor and grid ram
// depends on tgcw_pkg and tgcw_ram
`default_nettype none

module tgcw_back
    import tgcw_pkg::*;
#(
    parameter int COLUMNS = TGCW_COLUMNS,
    parameter int ROWS    = TGCW_ROWS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    output logic        o_run,
    input  wire         i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_cell_char,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic        o_redraw_hint
);

    localparam int RB    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CB    = $clog2(COLUMNS);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int TW    = $clog2(COLUMNS + TAB_MASK + 1);
    localparam int AW    = RB + CB;
    localparam int DEPTH = ROWS << CB;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_TAB   = 2'd2;
    localparam logic [1:0] S_RDW   = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [AW-1:0]  r_clr, n_clr;
    logic [RB-1:0]  r_row, n_row;
    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_tab_end, n_tab_end;
    logic           r_hint, n_hint;

    logic           r_ov;
    logic [7:0]     r_ochar;
    logic [4:0]     r_orow;
    logic [6:0]     r_ocol;
    logic           r_ohint;

    logic           w_emit;
    logic [7:0]     w_echar;
    logic           w_ehint;
    logic           w_out_free;
    logic           w_ram_we;
    logic [AW-1:0]  w_ram_wa;
    logic [7:0]     w_ram_wd;
    logic           w_ram_re;
    logic [AW-1:0]  w_ram_ra;
    logic [7:0]     w_ram_rd;

    logic [TW-1:0]  w_col_ext;
    logic [TW-1:0]  w_tgt;
    logic [CW-1:0]  w_tab_end;
    logic [RB:0]    w_row_inc;
    logic [7:0]     w_rr8;
    logic [7:0]     w_rc8;
    logic [RB+4:0]  w_orow_ext;
    logic [CW+6:0]  w_ocol_ext;

    tgcw_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_wa),
        .i_wdata (w_ram_wd),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_ra),
        .o_rdata (w_ram_rd)
    );

    assign w_out_free = !r_ov || i_m_tready;
    assign o_run      = (r_state != S_CLEAR);
    assign w_col_ext  = TW'(r_col);
    assign w_tgt      = (w_col_ext + TW'(TAB_MASK)) & ~TW'(TAB_MASK);
    assign w_tab_end  = (w_tgt > TW'(COLUMNS)) ? CW'(COLUMNS) : w_tgt[CW-1:0];
    assign w_row_inc  = {1'b0, r_row} + (RB+1)'(1);
    assign w_rr8      = {3'b0, i_q_cmd.read_row};
    assign w_rc8      = {1'b0, i_q_cmd.read_column};

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_row     = r_row;
        n_col     = r_col;
        n_tab_end = r_tab_end;
        n_hint    = r_hint;
        o_q_pop   = 1'b0;
        w_emit    = 1'b0;
        w_echar   = 8'h00;
        w_ehint   = r_hint;
        w_ram_we  = 1'b0;
        w_ram_wa  = {r_row, r_col[CB-1:0]};
        w_ram_wd  = CH_SPACE;
        w_ram_re  = 1'b0;
        w_ram_ra  = {w_rr8[RB-1:0], w_rc8[CB-1:0]};
        unique case (r_state)
            S_CLEAR: begin
                // zero the whole grid before the first item
                w_ram_we = 1'b1;
                w_ram_wa = r_clr;
                w_ram_wd = 8'h00;
                n_clr    = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_q_valid && w_out_free) begin
                    o_q_pop = 1'b1;
                    n_hint  = i_q_cmd.chunk_end;
                    w_ehint = i_q_cmd.chunk_end;
                    unique case (i_q_cmd.kind)
                        K_CR: begin
                            n_col  = '0;
                            w_emit = 1'b1;
                        end
                        K_LF: begin
                            n_row  = (w_row_inc >= (RB+1)'(ROWS)) ? '0 : w_row_inc[RB-1:0];
                            n_col  = '0;
                            w_emit = 1'b1;
                        end
                        K_TAB: begin
                            // at a tab stop or on a full row nothing is written
                            if (r_col[2:0] != 3'b000 && r_col < CW'(COLUMNS)) begin
                                n_tab_end = w_tab_end;
                                n_state   = S_TAB;
                            end else begin
                                n_col  = (w_tab_end > r_col) ? w_tab_end : r_col;
                                w_emit = 1'b1;
                            end
                        end
                        K_READ: begin
                            w_ehint = 1'b0;
                            if (i_q_cmd.in_range) begin
                                w_ram_re = 1'b1;
                                n_state  = S_RDW;
                            end else begin
                                w_emit = 1'b1;
                            end
                        end
                        default: begin
                            if (r_col < CW'(COLUMNS)) begin
                                w_ram_we = 1'b1;
                                w_ram_wd = i_q_cmd.byte_in;
                                n_col    = r_col + CW'(1);
                            end
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_TAB: begin
                w_ram_we = 1'b1;
                n_col    = r_col + CW'(1);
                if (r_col + CW'(1) == r_tab_end) begin
                    w_emit  = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: begin
                // registered ram read is back
                w_echar = w_ram_rd;
                w_ehint = 1'b0;
                w_emit  = 1'b1;
                n_state = S_RUN;
            end
        endcase
    end

    assign w_orow_ext = {5'b0, n_row};
    assign w_ocol_ext = {7'b0, n_col};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_row   <= n_row;
            r_col   <= n_col;
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tab_end <= n_tab_end;
        r_hint    <= n_hint;
        if (w_emit) begin
            r_ochar <= w_echar;
            r_orow  <= w_orow_ext[4:0];
            r_ocol  <= w_ocol_ext[6:0];
            r_ohint <= w_ehint;
        end
    end

    assign o_m_tvalid      = r_ov;
    assign o_cell_char     = r_ochar;
    assign o_cursor_row    = r_orow;
    assign o_cursor_column = r_ocol;
    assign o_redraw_hint   = r_ohint;

`ifndef NO_ASSERTIONS
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("command taken during grid clear");

    a_read_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDW) |=> o_m_tvalid)
        else $error("grid read produced no result");

    a_tab_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAB) |-> (r_col < CW'(COLUMNS)) && (r_col < r_tab_end))
        else $error("tab fill ran past its end");

    a_no_emit_over_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result overwrote an untaken result");
`endif

endmodule

`default_nettype wire

// ===== sv/text_grid_cursor_writer.sv =====
// top level of the text grid cursor writer: front queue plus back end
// depends on tgcw_pkg, tgcw_front, tgcw_back and tgcw_ram
`default_nettype none

// A ROWS by COLUMNS byte grid with a cursor, fed from a terminal byte stream
// and read back cell by cell; every input beat gives exactly one output beat
// carrying the cursor after the item. After reset the grid is zeroed by a
// clearing pass over all ROWS * 2**ceil(log2(COLUMNS)) addresses (3200 at 80
// by 25), during which no input beat is taken. A four-entry command queue sits
// between the input and the back end. In the back end an ordinary byte,
// carriage return or line feed is handled in the run state, a read waits in
// its own state for the grid ram's registered read port, and a tab off a stop
// writes its spaces one at a time in its own state up to the next stop or the
// row end; the grid ram's single write port and its registered read set these steps.
module text_grid_cursor_writer
    import tgcw_pkg::*;
#(
    parameter int COLUMNS = TGCW_COLUMNS,
    parameter int ROWS    = TGCW_ROWS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,   // byte_in[7:0], read_row[12:8], read_column[19:13], zeros
    input  wire         i_s_tuser,   // operation
    input  wire         i_s_tlast,   // chunk_end
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // cell_char[7:0], cursor_row[12:8], cursor_column[19:13]
    output logic        o_m_tlast    // redraw_hint
);

    logic       w_run;
    logic       w_q_valid;
    t_cmd       w_q_cmd;
    logic       w_q_pop;
    logic [7:0] w_cell_char;
    logic [4:0] w_cursor_row;
    logic [6:0] w_cursor_column;

    tgcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run         (w_run),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_operation   (i_s_tuser),
        .i_byte_in     (i_s_tdata[7:0]),
        .i_read_row    (i_s_tdata[12:8]),
        .i_read_column (i_s_tdata[19:13]),
        .i_chunk_end   (i_s_tlast),
        .o_q_valid     (w_q_valid),
        .o_q_cmd       (w_q_cmd),
        .i_q_pop       (w_q_pop)
    );

    tgcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .o_run           (w_run),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_cmd),
        .o_q_pop         (w_q_pop),
        .o_m_tvalid      (o_m_tvalid),
        .i_m_tready      (i_m_tready),
        .o_cell_char     (w_cell_char),
        .o_cursor_row    (w_cursor_row),
        .o_cursor_column (w_cursor_column),
        .o_redraw_hint   (o_m_tlast)
    );

    assign o_m_tdata = {4'b0, w_cursor_column, w_cursor_row, w_cell_char};

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// testbench for text_grid_cursor_writer: directed and random terminal byte streams and cell reads
// depends on tgcw_pkg and the block's rtl; every output beat is checked against an in-bench grid
// model
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tgcw_pkg::*;

    localparam logic OP_FEED      = 1'b0;
    localparam logic OP_READ      = 1'b1;
    localparam int   RANDOM_ITEMS = 500;
    localparam int   HOLD_CYCLES  = 100;
    localparam int   CYCLE_LIMIT  = 250000;

    typedef struct {
        logic [7:0] cell_char;
        logic [4:0] row;
        logic [6:0] column;
        logic       hint;
    } t_cursor_beat;

    // grid and cursor model plus the queue of beats still owed by the block
    class t_grid_scoreboard;
        logic [7:0]   cells [TGCW_ROWS][TGCW_COLUMNS];
        int unsigned  row_now;
        int unsigned  col_now;
        t_cursor_beat owed_q [$];
        int           errors;

        function new();
            for (int r = 0; r < TGCW_ROWS; r++)
                for (int c = 0; c < TGCW_COLUMNS; c++)
                    cells[r][c] = 8'h00;
            row_now = 0;
            col_now = 0;
            errors  = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void feed_byte(input logic [7:0] b);
            int unsigned stop;
            case (b)
                CH_CR: begin
                    col_now = 0;
                end
                CH_LF: begin
                    row_now = (row_now + 1 >= TGCW_ROWS) ? 0 : row_now + 1;
                    col_now = 0;
                end
                CH_TAB: begin
                    stop = (col_now + TAB_MASK) & ~TAB_MASK;
                    // spaces only land below the row end, the column saturates there
                    for (int unsigned c = col_now; c < stop; c++)
                        if (c < TGCW_COLUMNS)
                            cells[row_now][c] = CH_SPACE;
                    if (stop > TGCW_COLUMNS)
                        stop = TGCW_COLUMNS;
                    if (stop > col_now)
                        col_now = stop;
                end
                default: begin
                    if (col_now < TGCW_COLUMNS) begin
                        cells[row_now][col_now] = b;
                        col_now++;
                    end
                end
            endcase
        endfunction

        function void note_item(input logic op, input logic [7:0] b, input logic [4:0] rr,
                                input logic [6:0] rc, input logic last);
            t_cursor_beat exp_beat;
            exp_beat.cell_char = 8'h00;
            exp_beat.hint      = 1'b0;
            if (op == OP_FEED) begin
                feed_byte(b);
                exp_beat.hint = last;
            end else if (rr < TGCW_ROWS && rc < TGCW_COLUMNS) begin
                exp_beat.cell_char = cells[rr][rc];
            end
            exp_beat.row    = row_now[4:0];
            exp_beat.column = col_now[6:0];
            owed_q.push_back(exp_beat);
        endfunction

        task check_beat(input logic [7:0] cell_char, input logic [4:0] row,
                        input logic [6:0] column, input logic hint);
            t_cursor_beat exp_beat;
            if (owed_q.size() == 0) begin
                report("output beat with nothing expected");
            end else begin
                exp_beat = owed_q.pop_front();
                if (cell_char !== exp_beat.cell_char)
                    report($sformatf("cell_char got %02h expected %02h",
                                     cell_char, exp_beat.cell_char));
                if (row !== exp_beat.row)
                    report($sformatf("cursor row got %0d expected %0d", row, exp_beat.row));
                if (column !== exp_beat.column)
                    report($sformatf("cursor column got %0d expected %0d",
                                     column, exp_beat.column));
                if (hint !== exp_beat.hint)
                    report($sformatf("redraw hint got %b expected %b", hint, exp_beat.hint));
            end
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_valid  = 1'b0;
    logic [23:0] s_data   = '0;
    logic        s_op     = 1'b0;
    logic        s_last   = 1'b0;
    logic        m_ready  = 1'b0;
    logic        hold_req = 1'b0;
    wire         s_ready;
    wire         m_valid;
    wire  [23:0] m_data;
    wire         m_last;

    t_grid_scoreboard grid_sb;
    int               burst_left  = 0;
    int               items_sent  = 0;
    int               cycle_count = 0;

    text_grid_cursor_writer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_op),
        .i_s_tlast  (s_last),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tlast  (m_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready)
            grid_sb.check_beat(m_data[7:0], m_data[12:8], m_data[19:13], m_last);
    end

    // receiver: switches between always ready, coin toss and mostly stalled, plus one long hold
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_taken;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        hold_taken = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_taken = 1;
                hold_left  = HOLD_CYCLES;
                m_ready    <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // sender bursts: most new bursts open with a gap of random length
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_item(input logic op, input logic [7:0] b, input logic [4:0] rr,
                             input logic [6:0] rc, input logic last);
        pace();
        s_valid <= 1'b1;
        s_op    <= op;
        s_last  <= last;
        s_data  <= {4'b0000, rc, rr, b};
        do @(posedge clk); while (!s_ready);
        grid_sb.note_item(op, b, rr, rc, last);
        items_sent++;
    endtask

    task automatic feed(input logic [7:0] b, input logic last);
        send_item(OP_FEED, b, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)), last);
    endtask

    task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
        send_item(OP_READ, 8'($urandom_range(0, 255)), rr, rc, 1'($urandom_range(0, 1)));
    endtask

    function automatic logic [7:0] line_byte();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return 8'($urandom_range(8'h21, 8'h7E));
        else if (pick < 15)
            return CH_TAB;
        else if (pick < 17)
            return 8'($urandom_range(8'h80, 8'hFF));
        else
            return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int  len;
        int  pick;
        bit  hold_done;
        bit  drain_done;
        hold_done  = 0;
        drain_done = 0;
        grid_sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty grid, out of range reads, tab at and off a stop, cr, lf
        read_cell(5'd0, 7'd0);
        read_cell(5'd31, 7'd127);
        read_cell(5'(TGCW_ROWS), 7'd0);
        read_cell(5'd0, 7'(TGCW_COLUMNS));
        feed(8'h41, 1'b1);
        feed(8'hFF, 1'b0);
        feed(8'h00, 1'b0);
        feed(CH_TAB, 1'b0);
        feed(CH_TAB, 1'b1);
        feed(8'h55, 1'b0);
        feed(CH_CR, 1'b0);
        feed(CH_LF, 1'b1);
        read_cell(5'd0, 7'd0);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd4);
        read_cell(5'd0, 7'd8);
        read_cell(5'(TGCW_ROWS - 1), 7'(TGCW_COLUMNS - 1));
        send_item(OP_READ, 8'hFF, 5'd0, 7'd2, 1'b1);
        send_item(OP_FEED, CH_LF, 5'h1F, 7'h7F, 1'b0);
        send_item(OP_FEED, 8'hAA, 5'h1F, 7'h7F, 1'b1);

        // random: lines of text with tabs and reads, most short, some past the row end
        while (items_sent < 20 + RANDOM_ITEMS) begin
            if (!hold_done && items_sent > 150) begin
                hold_req   <= 1'b1;
                hold_done  = 1;
                burst_left = 60;
            end
            if (!drain_done && items_sent > 330) begin
                drain_done = 1;
                s_valid <= 1'b0;
                do @(posedge clk); while (grid_sb.pending() != 0);
            end
            if ($urandom_range(0, 19) == 0)
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)));
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 10) : $urandom_range(60, 100);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 3) == 0)
                    read_cell(5'(($urandom_range(0, 9) < 7) ? grid_sb.row_now
                                                            : $urandom_range(0, 31)),
                              7'(($urandom_range(0, 4) != 0) ? $urandom_range(0, 79)
                                                             : $urandom_range(0, 127)));
                else
                    feed(line_byte(), $urandom_range(0, 7) == 0);
            end
            pick = $urandom_range(0, 19);
            if (pick < 8) begin
                feed(CH_CR, 1'b0);
                feed(CH_LF, 1'($urandom_range(0, 1)));
            end else if (pick < 13) begin
                feed(CH_LF, 1'($urandom_range(0, 1)));
            end else if (pick < 16) begin
                feed(CH_CR, 1'($urandom_range(0, 1)));
            end else if (pick == 16) begin
                // run of line feeds so the row may wrap back to the top
                len = $urandom_range(10, 30);
                for (int k = 0; k < len; k++)
                    feed(CH_LF, 1'($urandom_range(0, 1)));
            end
        end

        s_valid <= 1'b0;
        while (grid_sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (grid_sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
